// ===== src/spjq_pkg.sv =====
// Package: shared types and codes for the stable priority job queue.
`default_nettype none
package spjq_pkg;

    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic POLICY_FCFS     = 1'b0;
    localparam logic POLICY_PRIORITY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Contents of one queue cell
    typedef struct packed {
        logic              occ;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              policy;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } ctrl_t;

    localparam entry_t EMPTY_ENTRY = '{occ: 1'b0, tag: '0, prio: '0};

endpackage
`default_nettype wire

// ===== src/spjq_if.sv =====
// Interfaces: job input, result output and policy configuration channels.
`default_nettype none
interface spjq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [spjq_pkg::TAG_W-1:0]  job_tag;
    logic [spjq_pkg::PRIO_W-1:0] job_priority;

    modport source (output valid, output mode, output job_tag, output job_priority,
                    input ready);
    modport sink   (input valid, input mode, input job_tag, input job_priority,
                    output ready);
endinterface

interface spjq_out_if;
    logic                         valid;
    logic                         ready;
    logic [spjq_pkg::STATUS_W-1:0] op_status;
    logic [spjq_pkg::TAG_W-1:0]    out_tag;
    logic [spjq_pkg::PRIO_W-1:0]   out_priority;
    logic [spjq_pkg::FILL_W-1:0]   fill_level;

    modport source (output valid, output op_status, output out_tag, output out_priority,
                    output fill_level, input ready);
    modport sink   (input valid, input op_status, input out_tag, input out_priority,
                    input fill_level, output ready);
endinterface

interface spjq_cfg_if;
    logic valid;
    logic ready;
    logic policy_select;

    modport source (output valid, output policy_select, input ready);
    modport sink   (input valid, input policy_select, output ready);
endinterface
`default_nettype wire

// ===== src/spjq_cell.sv =====
// One queue cell: holds a job and shifts toward the front or back with its neighbors.
`default_nettype none
module spjq_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spjq_pkg::ctrl_t   ctl,
    input  wire spjq_pkg::entry_t  prev_entry,
    input  wire spjq_pkg::entry_t  next_entry,
    input  wire logic              after_in,
    output logic                   after_out,
    output spjq_pkg::entry_t       entry
);

    logic                          occ_reg, occ_next;
    logic [spjq_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic [spjq_pkg::PRIO_W-1:0]   prio_reg, prio_next;
    logic                          gt;

    // A held job with a larger priority number marks the insert point
    assign gt        = occ_reg && (ctl.policy == spjq_pkg::POLICY_PRIORITY)
                       && (prio_reg > ctl.prio);
    assign after_out = after_in || !occ_reg || gt;

    always_comb
    begin
        occ_next  = occ_reg;
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctl.rem)
        begin
            occ_next  = next_entry.occ;
            tag_next  = next_entry.tag;
            prio_next = next_entry.prio;
        end
        else if (ctl.ins)
        begin
            if (after_in)
            begin
                occ_next  = prev_entry.occ;
                tag_next  = prev_entry.tag;
                prio_next = prev_entry.prio;
            end
            else if (after_out)
            begin
                occ_next  = 1'b1;
                tag_next  = ctl.tag;
                prio_next = ctl.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign entry = '{occ: occ_reg, tag: tag_reg, prio: prio_reg};

endmodule
`default_nettype wire

// ===== src/stable_priority_job_queue.sv =====
// Top level: stable priority job queue built as a chain of shifting cells.
// One transaction per cycle in both directions: every item is finished in the cycle it
// is accepted and its result is registered, so an insert or remove can follow each
// cycle while the result register drains. The insert point is found by an OR chain
// rippling through all QUEUE_DEPTH cells, which sets the critical path. Priority policy
// puts a job ahead of the first held job with a larger priority number; first-come
// policy and priority inserts with no such job append at the back. Removes always
// take the front cell. fill_level reports the job count modulo 32.
`default_nettype none
module stable_priority_job_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    spjq_in_if.sink     job_in,
    spjq_out_if.source  result_out,
    spjq_cfg_if.sink    cfg
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                          policy_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          res_valid_reg;
    logic [spjq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [spjq_pkg::TAG_W-1:0]    otag_reg, otag_next;
    logic [spjq_pkg::PRIO_W-1:0]   oprio_reg, oprio_next;
    logic [spjq_pkg::FILL_W-1:0]   fill_reg;

    logic              accept, full, empty;
    spjq_pkg::ctrl_t   ctl;
    spjq_pkg::entry_t  cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] after;

    assign cfg.ready    = 1'b1;
    assign job_in.ready = !res_valid_reg || result_out.ready;
    assign accept       = job_in.valid && job_in.ready;
    assign full         = (count_reg == CW'(QUEUE_DEPTH));
    assign empty        = (count_reg == '0);

    assign ctl.ins    = accept && (job_in.mode == spjq_pkg::MODE_INSERT) && !full;
    assign ctl.rem    = accept && (job_in.mode == spjq_pkg::MODE_REMOVE) && !empty;
    assign ctl.policy = policy_reg;
    assign ctl.tag    = job_in.job_tag;
    assign ctl.prio   = job_in.job_priority;

    assign after[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spjq_pkg::entry_t prev_e, next_e;
        if (i == 0)
        begin : g_first
            assign prev_e = spjq_pkg::EMPTY_ENTRY;
        end
        else
        begin : g_mid
            assign prev_e = cells[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_e = spjq_pkg::EMPTY_ENTRY;
        end
        else
        begin : g_inner
            assign next_e = cells[i+1];
        end

        spjq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .after_in   (after[i]),
            .after_out  (after[i+1]),
            .entry      (cells[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = spjq_pkg::STATUS_DONE;
        otag_next   = '0;
        oprio_next  = '0;
        if (job_in.mode == spjq_pkg::MODE_INSERT)
        begin
            if (full)
            begin
                status_next = spjq_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spjq_pkg::STATUS_EMPTY;
            end
            else
            begin
                count_next = count_reg - CW'(1);
                otag_next  = cells[0].tag;
                oprio_next = cells[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= spjq_pkg::POLICY_FCFS;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                policy_reg <= cfg.policy_select;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            otag_reg   <= otag_next;
            oprio_reg  <= oprio_next;
            fill_reg   <= spjq_pkg::FILL_W'(count_next);
        end
    end

    assign result_out.valid        = res_valid_reg;
    assign result_out.op_status    = status_reg;
    assign result_out.out_tag      = otag_reg;
    assign result_out.out_priority = oprio_reg;
    assign result_out.fill_level   = fill_reg;

endmodule
`default_nettype wire
